FILE: rtl/icaf_pkg.sv
// Shared constants, widths and coefficient table of the IMU complementary angle filter.
package icaf_pkg;

    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 16;

    // Shared multiplier operand and product/accumulator widths
    localparam int MUL_W = 35;
    localparam int ACC_W = 72;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET_Z = 2'd2;

    // Fixed-point scale factors
    localparam logic [63:0] Q30_ONE   = 64'd1073741824;
    localparam logic [31:0] HALF_PI   = 32'd1686629713;
    localparam logic [23:0] K_RATE    = 24'd262423;
    localparam logic [23:0] K_YAW     = 24'd1172079;
    localparam logic [23:0] K_DEG     = 24'd3754951;
    localparam logic [24:0] W_FUSE_OLD = 25'd16770505;
    localparam logic [24:0] W_FUSE_NEW = 25'd6711;
    localparam logic [24:0] W_DAMP_OLD = 25'd15099494;
    localparam logic [24:0] W_DAMP_NEW = 25'd1677722;

    // One third in Q35, rounded up; exact floor quotient for operands below 2^33
    localparam logic [33:0] RECIP_3   = 34'd11453246123;
    localparam int          RECIP_3_SH = 35;

    // asin polynomial coefficients, Q30
    function automatic logic signed [31:0] asin_coef(input logic [2:0] k);
        logic signed [31:0] c;
        case (k)
            3'd0:    c = 32'sd1686629690;
            3'd1:    c = -32'sd230423709;
            3'd2:    c = 32'sd95540460;
            3'd3:    c = -32'sd53874249;
            3'd4:    c = 32'sd33169905;
            3'd5:    c = -32'sd18348235;
            3'd6:    c = 32'sd7161955;
            default: c = -32'sd1355589;
        endcase
        return c;
    endfunction

    // Round to nearest, halves away from zero, shift s >= 1
    function automatic logic signed [ACC_W-1:0] rshr(input logic signed [ACC_W-1:0] v,
                                                     input logic [5:0] s);
        logic [ACC_W-1:0] m;
        m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        m = (m + (ACC_W'(1) << (s - 6'd1))) >> s;
        return v[ACC_W-1] ? -$signed(m) : $signed(m);
    endfunction

    // Saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1) begin
            r = v[31:0];
        end else begin
            r = v[ACC_W-1] ? 32'sh80000000 : 32'sh7fffffff;
        end
        return r;
    endfunction

endpackage

FILE: rtl/icaf_if.sv
// Request channels of the IMU complementary angle filter: sample, result and configuration.
interface icaf_in_if #(
    parameter int SAMPLE_BITS = icaf_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic signed [SAMPLE_BITS-1:0] rate_x;
    logic signed [SAMPLE_BITS-1:0] rate_y;
    logic signed [SAMPLE_BITS-1:0] rate_z;
    modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                    input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  output ready);
endinterface

interface icaf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pitch_smoothed;
    logic signed [31:0] roll_smoothed;
    logic signed [31:0] pitch_fused;
    logic signed [31:0] roll_fused;
    logic               accel_invalid;
    modport source (output valid, pitch_smoothed, roll_smoothed, pitch_fused, roll_fused,
                    accel_invalid, input ready);
    modport sink (input valid, pitch_smoothed, roll_smoothed, pitch_fused, roll_fused,
                  accel_invalid, output ready);
endinterface

interface icaf_cfg_if #(
    parameter int SAMPLE_BITS = icaf_pkg::SAMPLE_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic [icaf_pkg::CFG_IDX_W-1:0]     index;
    logic [SAMPLE_BITS-1:0]             data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/imu_complementary_angle_filter_core.sv
// IMU complementary pitch/roll filter: sequencer around one shared multiplier and a
// bit-serial divider / square-root unit.
//
// While a sample request is in work the sequencer runs two restoring divisions of DIV_N
// steps each (SAMPLE_BITS+30, at least 34; the two accelerometer ratios), three 32-step
// square roots (accelerometer magnitude and the two asin roots) and thirty-seven passes
// through the registered 35x35 multiplier (the division of the yaw cubic term by six is
// one of them, a reciprocal multiply). The first sample after reset skips the fusion
// multiplies; a zero accelerometer magnitude skips both angle computations.
// The sample channel is ready only while the sequencer is idle; a finished result sits in
// an output register, so the next sample may be taken while it waits. A result that is
// still waiting when the next one finishes holds the sequencer until it is taken.
// Gyro offsets are written through the configuration channel. The user must write them
// only while no sample is in work; the block itself does not enforce it.
module imu_complementary_angle_filter_core #(
    parameter int SAMPLE_BITS     = icaf_pkg::SAMPLE_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = icaf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    icaf_cfg_if.sink    i_cfg,
    icaf_in_if.sink     i_sample,
    icaf_out_if.source  o_result
);

    localparam int MW      = icaf_pkg::MUL_W;
    localparam int AW      = icaf_pkg::ACC_W;
    localparam int GW      = SAMPLE_BITS + 1;
    localparam int DIV_N   = (SAMPLE_BITS + 30 > 34) ? SAMPLE_BITS + 30 : 34;
    localparam int DV_W    = SAMPLE_BITS + 1;
    localparam int CNT_W   = $clog2(DIV_N);
    localparam logic [5:0] SH_RATE = 6'(32 - ANGLE_FRAC_BITS);
    localparam logic [5:0] SH_DEG  = 6'(46 - ANGLE_FRAC_BITS);

    typedef enum logic [30:0] {
        S_IDLE  = 31'd1 << 0,
        S_MWAIT = 31'd1 << 1,
        S_DIVW  = 31'd1 << 2,
        S_SQRTW = 31'd1 << 3,
        S_PINT  = 31'd1 << 4,
        S_RINT  = 31'd1 << 5,
        S_YX    = 31'd1 << 6,
        S_YX2   = 31'd1 << 7,
        S_YX3   = 31'd1 << 8,
        S_YSIN  = 31'd1 << 9,
        S_PYAW  = 31'd1 << 10,
        S_RYAW  = 31'd1 << 11,
        S_SQ1   = 31'd1 << 12,
        S_SQ2   = 31'd1 << 13,
        S_SQ3   = 31'd1 << 14,
        S_MAG   = 31'd1 << 15,
        S_RATIO = 31'd1 << 16,
        S_HORN  = 31'd1 << 17,
        S_ROOT  = 31'd1 << 18,
        S_ASIN  = 31'd1 << 19,
        S_DEG   = 31'd1 << 20,
        S_FUSE  = 31'd1 << 21,
        S_F1    = 31'd1 << 22,
        S_F2    = 31'd1 << 23,
        S_F3    = 31'd1 << 24,
        S_F4    = 31'd1 << 25,
        S_DAMP  = 31'd1 << 26,
        S_D1    = 31'd1 << 27,
        S_D2    = 31'd1 << 28,
        S_D3    = 31'd1 << 29,
        S_D4    = 31'd1 << 30
    } t_state;

    t_state r_state, r_ret;

    logic signed [SAMPLE_BITS-1:0] r_off_x, r_off_y, r_off_z;
    logic signed [GW-1:0]          r_gx, r_gy, r_gz;
    logic signed [SAMPLE_BITS-1:0] r_ax, r_ay, r_az;
    logic signed [MW-1:0]          r_ma, r_mb;
    logic signed [AW-1:0]          r_prod, r_acc;
    logic signed [31:0]            r_pe, r_re, r_pd, r_rd, r_pa, r_ra;
    logic                          r_seeded, r_inv, r_axis;
    logic signed [MW-1:0]          r_x, r_s, r_r, r_p;
    logic [2:0]                    r_k;
    logic [63:0]                   r_sum;
    logic [DIV_N-1:0]              r_dnum;
    logic [DV_W-1:0]               r_drem, r_dden, r_m;
    logic [63:0]                   r_snum;
    logic [33:0]                   r_srem;
    logic [31:0]                   r_sroot;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_ov;
    logic signed [31:0]            r_o_pd, r_o_rd, r_o_pf, r_o_rf;
    logic                          r_o_inv;

    logic signed [2*MW-1:0] w_mul;
    logic [5:0]             w_sh;
    logic signed [AW-1:0]   w_rnd;
    logic signed [31:0]     w_blend;
    logic signed [31:0]     w_pe_yaw;
    logic signed [MW-1:0]   w_xcap;
    logic [DIV_N-1:0]       w_rcap;
    logic signed [MW-1:0]   w_sm, w_sin;
    logic signed [AW-1:0]   w_res;
    logic signed [MW-1:0]   w_asin;
    logic signed [31:0]     w_deg;
    logic signed [MW-1:0]   w_pnew;
    logic signed [GW-1:0]   w_gz_abs;
    logic [GW-1:0]          w_aay, w_aax;
    logic [DV_W:0]          w_drem2;
    logic                   w_dge;
    logic [35:0]            w_srem2, w_strial;
    logic                   w_sge;
    logic                   w_acc_in;

    assign w_acc_in       = i_sample.valid && i_sample.ready;
    assign i_sample.ready = (r_state == S_IDLE);
    assign i_cfg.ready    = 1'b1;

    assign o_result.valid          = r_ov;
    assign o_result.pitch_smoothed = r_o_pd;
    assign o_result.roll_smoothed  = r_o_rd;
    assign o_result.pitch_fused    = r_o_pf;
    assign o_result.roll_fused     = r_o_rf;
    assign o_result.accel_invalid  = r_o_inv;

    // Pick the rounding shift of the product consumed in this step
    always_comb begin
        case (r_state)
            S_PINT, S_RINT: w_sh = SH_RATE;
            S_YX:           w_sh = 6'd10;
            S_DEG:          w_sh = SH_DEG;
            default:        w_sh = 6'd30;
        endcase
    end

    // Datapath helpers around the shared multiplier and the serial unit
    always_comb begin
        w_mul    = r_ma * r_mb;
        w_rnd    = icaf_pkg::rshr(r_prod, w_sh);
        w_blend  = icaf_pkg::sat32(icaf_pkg::rshr(r_acc + r_prod, 6'd24));
        w_pe_yaw = icaf_pkg::sat32(AW'(r_pe) + w_rnd);
        if (|w_rnd[AW-1:32] || (w_rnd[31] && |w_rnd[30:0])) begin
            w_xcap = MW'(64'h80000000);
        end else begin
            w_xcap = MW'(w_rnd);
        end
        if (|r_dnum[DIV_N-1:31] || (r_dnum[30] && |r_dnum[29:0])) begin
            w_rcap = DIV_N'(icaf_pkg::Q30_ONE);
        end else begin
            w_rcap = r_dnum;
        end
        // x - x^3/6, the quotient taken from the reciprocal product
        w_sm     = r_x - MW'(r_prod >>> icaf_pkg::RECIP_3_SH);
        w_sin    = r_gz[GW-1] ? -w_sm : w_sm;
        w_res    = AW'($signed({1'b0, icaf_pkg::HALF_PI})) - w_rnd;
        w_asin   = w_res[AW-1] ? '0 : MW'(w_res);
        w_deg    = icaf_pkg::sat32(w_rnd);
        w_pnew   = MW'(w_rnd + AW'(icaf_pkg::asin_coef(r_k)));
        w_gz_abs = r_gz[GW-1] ? -r_gz : r_gz;
        w_aay    = r_ay[SAMPLE_BITS-1] ? GW'(-GW'(r_ay)) : GW'(r_ay);
        w_aax    = r_ax[SAMPLE_BITS-1] ? GW'(-GW'(r_ax)) : GW'(r_ax);
        w_drem2  = {r_drem, r_dnum[DIV_N-1]};
        w_dge    = (w_drem2 >= {1'b0, r_dden});
        w_srem2  = {r_srem, r_snum[63:62]};
        w_strial = {2'b00, r_sroot, 2'b01};
        w_sge    = (w_srem2 >= w_strial);
    end

    // Register the shared product every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= AW'(w_mul);
    end

    // Take gyro offset writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= '0;
            r_off_y <= '0;
            r_off_z <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                icaf_pkg::CFG_GYRO_OFFSET_X: r_off_x <= i_cfg.data;
                icaf_pkg::CFG_GYRO_OFFSET_Y: r_off_y <= i_cfg.data;
                icaf_pkg::CFG_GYRO_OFFSET_Z: r_off_z <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_pe     <= '0;
            r_re     <= '0;
            r_pd     <= '0;
            r_rd     <= '0;
            r_seeded <= 1'b0;
            r_ov     <= 1'b0;
            r_cnt    <= '0;
            r_k      <= '0;
            r_axis   <= 1'b0;
        end else begin
            // Drop the result once taken; the final step reloads it instead
            if (o_result.ready && r_state != S_D4) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        r_ax    <= i_sample.accel_x;
                        r_ay    <= i_sample.accel_y;
                        r_az    <= i_sample.accel_z;
                        r_gx    <= GW'(i_sample.rate_x) - GW'(r_off_x);
                        r_gy    <= GW'(i_sample.rate_y) - GW'(r_off_y);
                        r_gz    <= GW'(i_sample.rate_z) - GW'(r_off_z);
                        r_ma    <= MW'(GW'(i_sample.rate_x) - GW'(r_off_x));
                        r_mb    <= MW'(icaf_pkg::K_RATE);
                        r_ret   <= S_PINT;
                        r_state <= S_MWAIT;
                    end
                end
                S_MWAIT: begin
                    r_state <= r_ret;
                end
                S_DIVW: begin
                    r_dnum <= {r_dnum[DIV_N-2:0], w_dge};
                    r_drem <= w_dge ? DV_W'(w_drem2 - {1'b0, r_dden}) : DV_W'(w_drem2);
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_N - 1)) begin
                        r_state <= r_ret;
                    end
                end
                S_SQRTW: begin
                    r_snum  <= r_snum << 2;
                    r_srem  <= w_sge ? 34'(w_srem2 - w_strial) : 34'(w_srem2);
                    r_sroot <= {r_sroot[30:0], w_sge};
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(31)) begin
                        r_state <= r_ret;
                    end
                end
                // Integrate pitch rate
                S_PINT: begin
                    r_pe    <= icaf_pkg::sat32(AW'(r_pe) + w_rnd);
                    r_ma    <= MW'(r_gy);
                    r_mb    <= MW'(icaf_pkg::K_RATE);
                    r_ret   <= S_RINT;
                    r_state <= S_MWAIT;
                end
                // Integrate roll rate
                S_RINT: begin
                    r_re    <= icaf_pkg::sat32(AW'(r_re) + w_rnd);
                    r_ma    <= MW'(w_gz_abs);
                    r_mb    <= MW'(icaf_pkg::K_YAW);
                    r_ret   <= S_YX;
                    r_state <= S_MWAIT;
                end
                // Yaw angle, clamped at 2 rad, then its square and cube
                S_YX: begin
                    r_x     <= w_xcap;
                    r_ma    <= w_xcap;
                    r_mb    <= w_xcap;
                    r_ret   <= S_YX2;
                    r_state <= S_MWAIT;
                end
                S_YX2: begin
                    r_ma    <= r_x;
                    r_mb    <= MW'(w_rnd);
                    r_ret   <= S_YX3;
                    r_state <= S_MWAIT;
                end
                // Divide the cube by six: halve, then multiply by one third
                S_YX3: begin
                    r_ma    <= MW'(w_rnd >>> 1);
                    r_mb    <= MW'(icaf_pkg::RECIP_3);
                    r_ret   <= S_YSIN;
                    r_state <= S_MWAIT;
                end
                // Sine done, couple yaw into pitch and roll
                S_YSIN: begin
                    r_s     <= w_sin;
                    r_ma    <= MW'(r_re);
                    r_mb    <= w_sin;
                    r_ret   <= S_PYAW;
                    r_state <= S_MWAIT;
                end
                S_PYAW: begin
                    r_pe    <= w_pe_yaw;
                    r_ma    <= MW'(w_pe_yaw);
                    r_mb    <= r_s;
                    r_ret   <= S_RYAW;
                    r_state <= S_MWAIT;
                end
                S_RYAW: begin
                    r_re    <= icaf_pkg::sat32(AW'(r_re) - w_rnd);
                    r_ma    <= MW'(r_ax);
                    r_mb    <= MW'(r_ax);
                    r_ret   <= S_SQ1;
                    r_state <= S_MWAIT;
                end
                // Accelerometer magnitude squared
                S_SQ1: begin
                    r_sum   <= 64'(r_prod);
                    r_ma    <= MW'(r_ay);
                    r_mb    <= MW'(r_ay);
                    r_ret   <= S_SQ2;
                    r_state <= S_MWAIT;
                end
                S_SQ2: begin
                    r_sum   <= r_sum + 64'(r_prod);
                    r_ma    <= MW'(r_az);
                    r_mb    <= MW'(r_az);
                    r_ret   <= S_SQ3;
                    r_state <= S_MWAIT;
                end
                S_SQ3: begin
                    r_snum  <= r_sum + 64'(r_prod);
                    r_srem  <= '0;
                    r_sroot <= '0;
                    r_cnt   <= '0;
                    r_ret   <= S_MAG;
                    r_state <= S_SQRTW;
                end
                // Flag a zero magnitude, else start the pitch ratio
                S_MAG: begin
                    r_inv <= (r_sroot == '0);
                    if (r_sroot == '0) begin
                        r_pa    <= '0;
                        r_ra    <= '0;
                        r_state <= S_FUSE;
                    end else begin
                        r_axis  <= 1'b0;
                        r_m     <= DV_W'(r_sroot);
                        r_dden  <= DV_W'(r_sroot);
                        r_dnum  <= DIV_N'(w_aay) << 30;
                        r_drem  <= '0;
                        r_cnt   <= '0;
                        r_ret   <= S_RATIO;
                        r_state <= S_DIVW;
                    end
                end
                // Clamp the ratio and start the asin polynomial
                S_RATIO: begin
                    r_r     <= MW'(w_rcap);
                    r_ma    <= MW'(icaf_pkg::asin_coef(3'd7));
                    r_mb    <= MW'(w_rcap);
                    r_k     <= 3'd6;
                    r_ret   <= S_HORN;
                    r_state <= S_MWAIT;
                end
                S_HORN: begin
                    r_p <= w_pnew;
                    if (r_k == 3'd0) begin
                        r_snum  <= (icaf_pkg::Q30_ONE - 64'(r_r)) << 30;
                        r_srem  <= '0;
                        r_sroot <= '0;
                        r_cnt   <= '0;
                        r_ret   <= S_ROOT;
                        r_state <= S_SQRTW;
                    end else begin
                        r_k     <= r_k - 3'd1;
                        r_ma    <= w_pnew;
                        r_mb    <= r_r;
                        r_ret   <= S_HORN;
                        r_state <= S_MWAIT;
                    end
                end
                S_ROOT: begin
                    r_ma    <= r_p;
                    r_mb    <= MW'(r_sroot);
                    r_ret   <= S_ASIN;
                    r_state <= S_MWAIT;
                end
                S_ASIN: begin
                    r_ma    <= w_asin;
                    r_mb    <= MW'(icaf_pkg::K_DEG);
                    r_ret   <= S_DEG;
                    r_state <= S_MWAIT;
                end
                // Signed degrees; then the roll axis, or on to fusion
                S_DEG: begin
                    if (!r_axis) begin
                        r_pa    <= r_ay[SAMPLE_BITS-1] ? -w_deg : w_deg;
                        r_axis  <= 1'b1;
                        r_dden  <= r_m;
                        r_dnum  <= DIV_N'(w_aax) << 30;
                        r_drem  <= '0;
                        r_cnt   <= '0;
                        r_ret   <= S_RATIO;
                        r_state <= S_DIVW;
                    end else begin
                        r_ra    <= r_ax[SAMPLE_BITS-1] ? w_deg : -w_deg;
                        r_state <= S_FUSE;
                    end
                end
                // Fuse, or seed from the accelerometer on the first sample
                S_FUSE: begin
                    if (r_seeded) begin
                        r_ma    <= MW'(r_pe);
                        r_mb    <= MW'(icaf_pkg::W_FUSE_OLD);
                        r_ret   <= S_F1;
                        r_state <= S_MWAIT;
                    end else begin
                        r_pe     <= r_pa;
                        r_re     <= r_ra;
                        r_seeded <= 1'b1;
                        r_state  <= S_DAMP;
                    end
                end
                S_F1: begin
                    r_acc   <= r_prod;
                    r_ma    <= MW'(r_pa);
                    r_mb    <= MW'(icaf_pkg::W_FUSE_NEW);
                    r_ret   <= S_F2;
                    r_state <= S_MWAIT;
                end
                S_F2: begin
                    r_pe    <= w_blend;
                    r_ma    <= MW'(r_re);
                    r_mb    <= MW'(icaf_pkg::W_FUSE_OLD);
                    r_ret   <= S_F3;
                    r_state <= S_MWAIT;
                end
                S_F3: begin
                    r_acc   <= r_prod;
                    r_ma    <= MW'(r_ra);
                    r_mb    <= MW'(icaf_pkg::W_FUSE_NEW);
                    r_ret   <= S_F4;
                    r_state <= S_MWAIT;
                end
                S_F4: begin
                    r_re    <= w_blend;
                    r_state <= S_DAMP;
                end
                // Damp the fused angles
                S_DAMP: begin
                    r_ma    <= MW'(r_pd);
                    r_mb    <= MW'(icaf_pkg::W_DAMP_OLD);
                    r_ret   <= S_D1;
                    r_state <= S_MWAIT;
                end
                S_D1: begin
                    r_acc   <= r_prod;
                    r_ma    <= MW'(r_pe);
                    r_mb    <= MW'(icaf_pkg::W_DAMP_NEW);
                    r_ret   <= S_D2;
                    r_state <= S_MWAIT;
                end
                S_D2: begin
                    r_pd    <= w_blend;
                    r_ma    <= MW'(r_rd);
                    r_mb    <= MW'(icaf_pkg::W_DAMP_OLD);
                    r_ret   <= S_D3;
                    r_state <= S_MWAIT;
                end
                S_D3: begin
                    r_acc   <= r_prod;
                    r_ma    <= MW'(r_re);
                    r_mb    <= MW'(icaf_pkg::W_DAMP_NEW);
                    r_ret   <= S_D4;
                    r_state <= S_MWAIT;
                end
                // Hold until the output register is free, then load the result
                S_D4: begin
                    if (!r_ov || o_result.ready) begin
                        r_rd    <= w_blend;
                        r_o_pd  <= r_pd;
                        r_o_rd  <= w_blend;
                        r_o_pf  <= r_pe;
                        r_o_rf  <= r_re;
                        r_o_inv <= r_inv;
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_in |=> (r_state == S_MWAIT))
        else $error("sample request did not start the multiply sequence");

    a_seeded_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seeded |=> r_seeded)
        else $error("seeded flag cleared without reset");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVW) |-> (r_cnt <= CNT_W'(DIV_N - 1)))
        else $error("divider step count overran");
`endif

endmodule
